// File: design/windowed_sensor_average_defines.svh
// Assertion macros used by the checker file of windowed_sensor_average.
// Expects signals named clk and rst_n in the scope where a macro is used.
`ifndef WINDOWED_SENSOR_AVERAGE_DEFINES_SVH
`define WINDOWED_SENSOR_AVERAGE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define WSA_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define WSA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/wsa_pkg.sv
// Shared types and constants of windowed_sensor_average.
// No dependencies; used by wsa_front, wsa_back, the top level and the checker.
`default_nettype none

package wsa_pkg;

    localparam int WINDOW_DEPTH_DEF = 16;

    localparam int TEMP_W  = 12;
    localparam int HUM_W   = 10;
    localparam int LIGHT_W = 10;
    localparam int COUNT_W = 5;

    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 48;

    typedef enum logic {
        OP_PUSH  = 1'b0,
        OP_CLEAR = 1'b1
    } op_t;

    // Last member sits in the lowest bits, matching the tdata packing.
    typedef struct packed {
        logic [LIGHT_W-1:0]       light_sample;
        logic                     hum_ok;
        logic [HUM_W-1:0]         hum_sample;
        logic                     temp_ok;
        logic signed [TEMP_W-1:0] temp_sample;
    } slot_t;

    typedef struct packed {
        op_t   op;
        slot_t slot;
    } cmd_t;

    typedef struct packed {
        logic [COUNT_W-1:0]       fill_count;
        logic [COUNT_W-1:0]       hum_count;
        logic [COUNT_W-1:0]       temp_count;
        logic [LIGHT_W-1:0]       light_average;
        logic [HUM_W-1:0]         hum_average;
        logic signed [TEMP_W-1:0] temp_average;
    } result_t;

    localparam int SLOT_W   = $bits(slot_t);
    localparam int RESULT_W = $bits(result_t);

endpackage

`default_nettype wire

// File: design/wsa_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module wsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// File: design/wsa_div.sv
// Serial restoring divider, one quotient bit per cycle.
// No package dependencies; used by wsa_back.
`default_nettype none

module wsa_div #(
    parameter int DIVIDEND_W = 16,
    parameter int DIVISOR_W  = 5
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire logic [DIVIDEND_W-1:0] dividend,
    input  wire logic [DIVISOR_W-1:0]  divisor,
    output logic                       done,
    output logic      [DIVIDEND_W-1:0] quotient
);

    localparam int STEP_W = $clog2(DIVIDEND_W + 1);

    logic                  run_reg,  run_next;
    logic                  done_reg, done_next;
    logic [STEP_W-1:0]     step_reg, step_next;
    logic [DIVIDEND_W-1:0] quo_reg,  quo_next;
    logic [DIVISOR_W-1:0]  rem_reg,  rem_next;
    logic [DIVISOR_W-1:0]  den_reg,  den_next;
    logic [DIVISOR_W:0]    trial;
    logic [DIVISOR_W:0]    diff;
    logic                  fits;

    assign trial = {rem_reg, quo_reg[DIVIDEND_W-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign fits  = trial >= {1'b0, den_reg};

    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        step_next = step_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        if (start)
        begin
            run_next  = 1'b1;
            step_next = STEP_W'(DIVIDEND_W);
            quo_next  = dividend;
            rem_next  = '0;
            den_next  = divisor;
        end
        else if (run_reg)
        begin
            quo_next  = {quo_reg[DIVIDEND_W-2:0], fits};
            rem_next  = fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
            step_next = step_reg - STEP_W'(1);
            if (step_reg == STEP_W'(1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

// File: design/wsa_front.sv
// Input side: accepts transactions, decodes the op and queues commands.
// Depends on wsa_pkg.
`default_nettype none

module wsa_front (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           s_tvalid,
    output logic                s_tready,
    input  wire logic           s_tuser,
    input  wire wsa_pkg::slot_t s_slot,
    output logic                q_valid,
    output wsa_pkg::cmd_t       q_data,
    input  wire logic           q_pop
);

    localparam int QDEPTH = 2;
    localparam int QA_W   = $clog2(QDEPTH);
    localparam int QC_W   = $clog2(QDEPTH + 1);

    wsa_pkg::cmd_t    q_mem [QDEPTH];
    wsa_pkg::cmd_t    cmd_in;
    logic [QA_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QA_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QC_W-1:0]  cnt_reg,    cnt_next;
    logic             push;
    logic             pop;

    // Classify: tuser carries the op code.
    always_comb
    begin
        cmd_in.op   = wsa_pkg::op_t'(s_tuser);
        cmd_in.slot = s_slot;
    end

    assign s_tready = cnt_reg != QC_W'(QDEPTH);
    assign q_valid  = cnt_reg != '0;
    assign push     = s_tvalid && s_tready;
    assign pop      = q_pop && q_valid;
    assign q_data   = q_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + QA_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + QA_W'(1) : rd_ptr_reg;
        cnt_next    = cnt_reg + QC_W'(push) - QC_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= cmd_in;
        end
    end

endmodule

`default_nettype wire

// File: design/wsa_back.sv
// Execution side: window storage, running sums, shared divider, result register.
// Depends on wsa_pkg, wsa_ram and wsa_div.
`default_nettype none

module wsa_back #(
    parameter int WINDOW_DEPTH = wsa_pkg::WINDOW_DEPTH_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          q_valid,
    input  wire wsa_pkg::cmd_t q_data,
    output logic               q_pop,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    output wsa_pkg::result_t   m_result
);

    localparam int TEMP_W  = wsa_pkg::TEMP_W;
    localparam int HUM_W   = wsa_pkg::HUM_W;
    localparam int LIGHT_W = wsa_pkg::LIGHT_W;
    localparam int COUNT_W = wsa_pkg::COUNT_W;
    localparam int SLOT_W  = wsa_pkg::SLOT_W;
    localparam int PTR_W   = $clog2(WINDOW_DEPTH);
    localparam int CNT_W   = $clog2(WINDOW_DEPTH + 1);
    localparam int TSUM_W  = TEMP_W + CNT_W;
    localparam int HSUM_W  = HUM_W + CNT_W;
    localparam int LSUM_W  = LIGHT_W + CNT_W;
    localparam int DIV_W   = TSUM_W - 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_UPD,
        S_START,
        S_WAIT,
        S_EMIT
    } state_t;

    typedef enum logic [1:0] {
        SEL_TEMP,
        SEL_HUM,
        SEL_LIGHT
    } sel_t;

    state_t                   state_reg, state_next;
    sel_t                     sel_reg,   sel_next;
    logic [PTR_W-1:0]         ptr_reg,   ptr_next;
    logic                     full_reg,  full_next;
    logic signed [TSUM_W-1:0] tsum_reg,  tsum_next;
    logic [HSUM_W-1:0]        hsum_reg,  hsum_next;
    logic [LSUM_W-1:0]        lsum_reg,  lsum_next;
    logic [CNT_W-1:0]         tcnt_reg,  tcnt_next;
    logic [CNT_W-1:0]         hcnt_reg,  hcnt_next;
    logic                     out_valid_reg, out_valid_next;

    wsa_pkg::slot_t           slot_reg;
    logic [TEMP_W-1:0]        tavg_reg;
    logic [HUM_W-1:0]         havg_reg;
    logic [LIGHT_W-1:0]       lavg_reg;
    wsa_pkg::result_t         out_reg;

    logic [SLOT_W-1:0]        old_raw;
    wsa_pkg::slot_t           old_slot;
    logic                     ram_we;
    logic                     take;
    logic                     out_free;
    logic [CNT_W-1:0]         fill;
    logic                     drop_t;
    logic                     drop_h;
    logic [TSUM_W-1:0]        t_old_ext;
    logic [TSUM_W-1:0]        t_new_ext;
    logic [TSUM_W-1:0]        t_mag_full;
    logic                     t_neg;
    logic                     div_start;
    logic                     div_done;
    logic [DIV_W-1:0]         div_dividend;
    logic [CNT_W-1:0]         div_divisor;
    logic [DIV_W-1:0]         div_quo;
    logic [TEMP_W-1:0]        q_temp;

    wsa_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (WINDOW_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ptr_reg),
        .wdata (slot_reg),
        .raddr (ptr_reg),
        .rdata (old_raw)
    );

    wsa_div #(
        .DIVIDEND_W (DIV_W),
        .DIVISOR_W  (CNT_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign old_slot = old_raw;
    assign q_pop    = (state_reg == S_IDLE) && q_valid;
    assign take     = q_pop;
    assign ram_we   = state_reg == S_UPD;
    assign out_free = !out_valid_reg || m_tready;
    assign fill     = full_reg ? CNT_W'(WINDOW_DEPTH) : CNT_W'(ptr_reg);
    assign drop_t   = full_reg && old_slot.temp_ok;
    assign drop_h   = full_reg && old_slot.hum_ok;

    assign t_old_ext = {{(TSUM_W-TEMP_W){old_slot.temp_sample[TEMP_W-1]}},
                        old_slot.temp_sample};
    assign t_new_ext = {{(TSUM_W-TEMP_W){slot_reg.temp_sample[TEMP_W-1]}},
                        slot_reg.temp_sample};

    // Magnitude never reaches the most negative code, so DIV_W bits hold it.
    assign t_neg      = tsum_reg[TSUM_W-1];
    assign t_mag_full = t_neg ? -tsum_reg : tsum_reg;
    assign q_temp     = div_quo[TEMP_W-1:0];

    always_comb
    begin
        case (sel_reg)
            SEL_TEMP:
            begin
                div_dividend = t_mag_full[DIV_W-1:0];
                div_divisor  = tcnt_reg;
            end
            SEL_HUM:
            begin
                div_dividend = DIV_W'(hsum_reg);
                div_divisor  = hcnt_reg;
            end
            SEL_LIGHT:
            begin
                div_dividend = DIV_W'(lsum_reg);
                div_divisor  = fill;
            end
            default:
            begin
                div_dividend = '0;
                div_divisor  = '0;
            end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        sel_next       = sel_reg;
        ptr_next       = ptr_reg;
        full_next      = full_reg;
        tsum_next      = tsum_reg;
        hsum_next      = hsum_reg;
        lsum_next      = lsum_reg;
        tcnt_next      = tcnt_reg;
        hcnt_next      = hcnt_reg;
        out_valid_next = out_valid_reg && !m_tready;
        div_start      = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (take)
                begin
                    if (q_data.op == wsa_pkg::OP_CLEAR)
                    begin
                        ptr_next   = '0;
                        full_next  = 1'b0;
                        tsum_next  = '0;
                        hsum_next  = '0;
                        lsum_next  = '0;
                        tcnt_next  = '0;
                        hcnt_next  = '0;
                        sel_next   = SEL_TEMP;
                        state_next = S_START;
                    end
                    else
                    begin
                        state_next = S_UPD;
                    end
                end
            end
            S_UPD:
            begin
                // Retire the overwritten slot, then add the new one.
                tsum_next = tsum_reg - (drop_t ? t_old_ext : '0)
                          + (slot_reg.temp_ok ? t_new_ext : '0);
                hsum_next = hsum_reg - (drop_h ? HSUM_W'(old_slot.hum_sample) : '0)
                          + (slot_reg.hum_ok ? HSUM_W'(slot_reg.hum_sample) : '0);
                lsum_next = lsum_reg - (full_reg ? LSUM_W'(old_slot.light_sample) : '0)
                          + LSUM_W'(slot_reg.light_sample);
                tcnt_next = tcnt_reg - CNT_W'(drop_t) + CNT_W'(slot_reg.temp_ok);
                hcnt_next = hcnt_reg - CNT_W'(drop_h) + CNT_W'(slot_reg.hum_ok);
                if (ptr_reg == PTR_W'(WINDOW_DEPTH - 1))
                begin
                    ptr_next  = '0;
                    full_next = 1'b1;
                end
                else
                begin
                    ptr_next = ptr_reg + PTR_W'(1);
                end
                sel_next   = SEL_TEMP;
                state_next = S_START;
            end
            S_START:
            begin
                div_start  = 1'b1;
                state_next = S_WAIT;
            end
            S_WAIT:
            begin
                if (div_done)
                begin
                    case (sel_reg)
                        SEL_TEMP:
                        begin
                            sel_next   = SEL_HUM;
                            state_next = S_START;
                        end
                        SEL_HUM:
                        begin
                            sel_next   = SEL_LIGHT;
                            state_next = S_START;
                        end
                        default:
                        begin
                            state_next = S_EMIT;
                        end
                    endcase
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            sel_reg       <= SEL_TEMP;
            ptr_reg       <= '0;
            full_reg      <= 1'b0;
            tsum_reg      <= '0;
            hsum_reg      <= '0;
            lsum_reg      <= '0;
            tcnt_reg      <= '0;
            hcnt_reg      <= '0;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            sel_reg       <= sel_next;
            ptr_reg       <= ptr_next;
            full_reg      <= full_next;
            tsum_reg      <= tsum_next;
            hsum_reg      <= hsum_next;
            lsum_reg      <= lsum_next;
            tcnt_reg      <= tcnt_next;
            hcnt_reg      <= hcnt_next;
            out_valid_reg <= out_valid_next;
            if ((state_reg == S_EMIT) && out_free)
            begin
                out_reg.temp_average  <= tavg_reg;
                out_reg.hum_average   <= havg_reg;
                out_reg.light_average <= lavg_reg;
                out_reg.temp_count    <= COUNT_W'(tcnt_reg);
                out_reg.hum_count     <= COUNT_W'(hcnt_reg);
                out_reg.fill_count    <= COUNT_W'(fill);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            slot_reg <= q_data.slot;
        end
        if ((state_reg == S_WAIT) && div_done)
        begin
            case (sel_reg)
                SEL_TEMP:
                begin
                    if (tcnt_reg == '0)
                    begin
                        tavg_reg <= '0;
                    end
                    else
                    begin
                        tavg_reg <= t_neg ? -q_temp : q_temp;
                    end
                end
                SEL_HUM:
                begin
                    havg_reg <= (hcnt_reg == '0) ? '0 : div_quo[HUM_W-1:0];
                end
                default:
                begin
                    lavg_reg <= (fill == '0) ? '0 : div_quo[LIGHT_W-1:0];
                end
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_result = out_reg;

endmodule

`default_nettype wire

// File: design/windowed_sensor_average.sv
// Top level of windowed_sensor_average: moving averages over a sample window.
// Depends on wsa_pkg, wsa_front and wsa_back.
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+-------------------------------------
//  s_*      | in        | s_tvalid/s_tready  | s_tdata sample set, s_tuser op
//  m_*      | out       | m_tvalid/m_tready  | m_tdata averages and counts
//
// Each item runs through the single serial divider, which produces the three quotients,
// each DIV_W = 11 + clog2(WINDOW_DEPTH + 1) bits wide, one after the other, one bit per
// cycle. The front queue holds two transactions, so up to two more are accepted while
// the back works or while a result waits on m_tready. Reset clears sums, counts,
// pointer and queue at once; slot storage is never cleared, as a slot is read only
// after being written.
`default_nettype none

module windowed_sensor_average #(
    parameter int WINDOW_DEPTH = wsa_pkg::WINDOW_DEPTH_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // temp_sample[11:0], temp_ok[12], hum_sample[22:13], hum_ok[23],
    // light_sample[33:24], zero fill [39:34]
    input  wire logic [wsa_pkg::S_TDATA_W-1:0] s_tdata,
    // op[0]: push or clear
    input  wire logic                          s_tuser,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // temp_average[11:0], hum_average[21:12], light_average[31:22],
    // temp_count[36:32], hum_count[41:37], fill_count[46:42], zero fill [47]
    output logic      [wsa_pkg::M_TDATA_W-1:0] m_tdata
);

    wsa_pkg::slot_t   s_slot;
    wsa_pkg::cmd_t    q_data;
    wsa_pkg::result_t m_result;
    logic             q_valid;
    logic             q_pop;

    // Drop the byte padding; the sample fields sit in the low bits.
    assign s_slot = s_tdata[wsa_pkg::SLOT_W-1:0];

    // Front: accept transactions and queue decoded commands.
    wsa_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_slot   (s_slot),
        .q_valid  (q_valid),
        .q_data   (q_data),
        .q_pop    (q_pop)
    );

    // Back: update the window, divide, hold the result until taken.
    wsa_back #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_data   (q_data),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_result (m_result)
    );

    // Pad the result out to whole bytes.
    assign m_tdata = {{(wsa_pkg::M_TDATA_W - wsa_pkg::RESULT_W){1'b0}}, m_result};

endmodule

`default_nettype wire

// File: design/wsa_checker.sv
// Port-level checks for windowed_sensor_average, bound to the top level.
// Depends on wsa_pkg and windowed_sensor_average_defines.svh.
`default_nettype none
`include "windowed_sensor_average_defines.svh"

module wsa_checker #(
    parameter int WINDOW_DEPTH = wsa_pkg::WINDOW_DEPTH_DEF
) (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          m_tvalid,
    input wire logic                          m_tready,
    input wire logic [wsa_pkg::M_TDATA_W-1:0] m_tdata
);

    // Counts are exact only while the window fits the 5-bit count fields.
    localparam bit COUNTS_EXACT = WINDOW_DEPTH < 32;
    localparam int COUNT_W      = wsa_pkg::COUNT_W;

    wsa_pkg::result_t res;
    logic             counts_ok;
    logic             zeros_ok;

    assign res = m_tdata[wsa_pkg::RESULT_W-1:0];

    assign counts_ok = (res.temp_count <= res.fill_count)
                    && (res.hum_count <= res.fill_count)
                    && (res.fill_count <= COUNT_W'(WINDOW_DEPTH));

    assign zeros_ok = ((res.temp_count != '0) || (res.temp_average == '0))
                   && ((res.hum_count != '0) || (res.hum_average == '0))
                   && ((res.fill_count != '0) || (res.light_average == '0));

    `WSA_ASSERT_NEXT(a_out_held, m_tvalid && !m_tready, m_tvalid,
                     "result dropped while stalled")
    `WSA_ASSERT_NEXT(a_out_stable, m_tvalid && !m_tready, $stable(m_tdata),
                     "result changed while stalled")
    `WSA_ASSERT_IMPL(a_counts, m_tvalid && COUNTS_EXACT, counts_ok,
                     "valid counts exceed fill count or window depth")
    `WSA_ASSERT_IMPL(a_empty_zero, m_tvalid && COUNTS_EXACT, zeros_ok,
                     "nonzero average over no counted samples")

endmodule

bind windowed_sensor_average wsa_checker #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
) u_wsa_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
